@@ hdl/havu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// havu_pkg
// Shared types and constants for the hierarchical address validator: the
// configuration record, verdict codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package havu_pkg;

    localparam int unsigned CntW = 4;
    localparam logic [CntW-1:0] CntMax = '1;

    typedef struct packed {
        logic [CntW-1:0] call_min_length;
        logic [CntW-1:0] call_max_length;
        logic [CntW-1:0] call_max_digits;
        logic [CntW-1:0] min_dot_count;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        call_min_length: 4'd3,
        call_max_length: 4'd6,
        call_max_digits: 4'd2,
        min_dot_count:   4'd2
    };

    typedef enum logic [1:0] {
        REG_CALL_MIN_LENGTH = 2'd0,
        REG_CALL_MAX_LENGTH = 2'd1,
        REG_CALL_MAX_DIGITS = 2'd2,
        REG_MIN_DOT_COUNT   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        REASON_OK         = 3'd0,
        REASON_BAD_CALL   = 3'd1,
        REASON_DOUBLE_DOT = 3'd2,
        REASON_ILLEGAL    = 3'd3,
        REASON_ENDS_DOT   = 3'd4,
        REASON_FEW_DOTS   = 3'd5
    } t_reason;

    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChLowZ  = 8'h7A;

endpackage

@@ hdl/havu_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// havu_core
// Per-address check state: callsign counters, dot tracking and the verdict
// for the item in the input register. State advances on i_advance and is
// cleared after a final item.
// ----------------------------------------------------------------------------
module havu_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [7:0]        i_char_code,
    input  wire logic              i_final_char,
    input  wire havu_pkg::t_cfg    i_cfg,
    output havu_pkg::t_reason      o_reason
);

    logic                      r_in_first_part, n_in_first_part;
    logic [havu_pkg::CntW-1:0] r_call_length,   n_call_length;
    logic [havu_pkg::CntW-1:0] r_call_digits,   n_call_digits;
    logic                      r_call_nonalnum, n_call_nonalnum;
    logic                      r_call_failed,   n_call_failed;
    logic                      r_prev_dot,      n_prev_dot;
    logic                      r_double_dot,    n_double_dot;
    logic                      r_illegal,       n_illegal;
    logic [havu_pkg::CntW-1:0] r_dots_seen,     n_dots_seen;

    logic is_dot, is_digit, is_upper, is_lower;

    assign is_dot   = (i_char_code == havu_pkg::ChDot);
    assign is_digit = (i_char_code >= havu_pkg::ChZero) && (i_char_code <= havu_pkg::ChNine);
    assign is_upper = (i_char_code >= havu_pkg::ChUpA)  && (i_char_code <= havu_pkg::ChUpZ);
    assign is_lower = (i_char_code >= havu_pkg::ChLowA) && (i_char_code <= havu_pkg::ChLowZ);

    always_comb begin
        n_in_first_part = r_in_first_part;
        n_call_length   = r_call_length;
        n_call_digits   = r_call_digits;
        n_call_nonalnum = r_call_nonalnum;
        n_call_failed   = r_call_failed;
        n_double_dot    = r_double_dot;
        n_dots_seen     = r_dots_seen;
        n_prev_dot      = is_dot;
        n_illegal       = r_illegal
                          | ~(is_digit | is_upper | is_dot | (i_char_code == havu_pkg::ChHash));

        if (is_dot) begin
            if (r_prev_dot) begin
                n_double_dot = 1'b1;
            end
            if (r_in_first_part) begin
                n_call_failed = r_call_nonalnum
                                | (r_call_length < i_cfg.call_min_length)
                                | (r_call_length > i_cfg.call_max_length)
                                | (r_call_digits == '0)
                                | (r_call_digits > i_cfg.call_max_digits);
                n_in_first_part = 1'b0;
            end
            if (r_dots_seen != havu_pkg::CntMax) begin
                n_dots_seen = r_dots_seen + 1'b1;
            end
        end else if (r_in_first_part) begin
            if (!(is_digit | is_upper | is_lower)) begin
                n_call_nonalnum = 1'b1;
            end
            if (is_digit && (r_call_digits != havu_pkg::CntMax)) begin
                n_call_digits = r_call_digits + 1'b1;
            end
            if (r_call_length != havu_pkg::CntMax) begin
                n_call_length = r_call_length + 1'b1;
            end
        end
    end

    always_comb begin
        priority if (n_call_failed) begin
            o_reason = havu_pkg::REASON_BAD_CALL;
        end else if (n_double_dot) begin
            o_reason = havu_pkg::REASON_DOUBLE_DOT;
        end else if (n_illegal) begin
            o_reason = havu_pkg::REASON_ILLEGAL;
        end else if (n_prev_dot) begin
            o_reason = havu_pkg::REASON_ENDS_DOT;
        end else if (n_dots_seen < i_cfg.min_dot_count) begin
            o_reason = havu_pkg::REASON_FEW_DOTS;
        end else begin
            o_reason = havu_pkg::REASON_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_final_char)) begin
            r_in_first_part <= 1'b1;
            r_call_length   <= '0;
            r_call_digits   <= '0;
            r_call_nonalnum <= 1'b0;
            r_call_failed   <= 1'b0;
            r_prev_dot      <= 1'b0;
            r_double_dot    <= 1'b0;
            r_illegal       <= 1'b0;
            r_dots_seen     <= '0;
        end else if (i_advance) begin
            r_in_first_part <= n_in_first_part;
            r_call_length   <= n_call_length;
            r_call_digits   <= n_call_digits;
            r_call_nonalnum <= n_call_nonalnum;
            r_call_failed   <= n_call_failed;
            r_prev_dot      <= n_prev_dot;
            r_double_dot    <= n_double_dot;
            r_illegal       <= n_illegal;
            r_dots_seen     <= n_dots_seen;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hierarchical_address_validator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_address_validator_unit
// Checks a dotted home address streamed one character per item and returns
// one verdict with the final character.
// ----------------------------------------------------------------------------
// Takes one character item per clock cycle, unless a stall on the result
// side holds back a final character, with no gaps between addresses. Each
// item lands in an input register, the check state updates from it as it
// leaves, and the verdict for a final character is held in an output
// register. The output register lets the next items enter while a verdict
// waits; a stall on the result side blocks input only when a second final
// character reaches the check stage. Limits are written over the APB port.
// ----------------------------------------------------------------------------
module hierarchical_address_validator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_final_char,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic        o_accepted,
    output      logic [2:0]  o_fail_reason
);

    havu_pkg::t_cfg     r_cfg;
    havu_pkg::t_reg_idx reg_idx;
    havu_pkg::t_reason  reason;
    logic               cfg_write;

    logic       r_in_valid;
    logic [7:0] r_char_code;
    logic       r_final_char;
    logic       advance;
    logic       out_free;

    logic       r_out_valid;
    logic       r_accepted;
    logic [2:0] r_fail_reason;

    assign reg_idx   = havu_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= havu_pkg::CfgReset;
        end else if (cfg_write) begin
            unique case (reg_idx)
                havu_pkg::REG_CALL_MIN_LENGTH: r_cfg.call_min_length <= pwdata[3:0];
                havu_pkg::REG_CALL_MAX_LENGTH: r_cfg.call_max_length <= pwdata[3:0];
                havu_pkg::REG_CALL_MAX_DIGITS: r_cfg.call_max_digits <= pwdata[3:0];
                havu_pkg::REG_MIN_DOT_COUNT:   r_cfg.min_dot_count   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            havu_pkg::REG_CALL_MIN_LENGTH: prdata = {28'd0, r_cfg.call_min_length};
            havu_pkg::REG_CALL_MAX_LENGTH: prdata = {28'd0, r_cfg.call_max_length};
            havu_pkg::REG_CALL_MAX_DIGITS: prdata = {28'd0, r_cfg.call_max_digits};
            havu_pkg::REG_MIN_DOT_COUNT:   prdata = {28'd0, r_cfg.min_dot_count};
            default:                       prdata = '0;
        endcase
    end

    assign out_free   = ~r_out_valid | i_out_ready;
    assign advance    = r_in_valid & (~r_final_char | out_free);
    assign o_in_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char_code  <= i_char_code;
            r_final_char <= i_final_char;
        end
    end

    havu_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_char_code  (r_char_code),
        .i_final_char (r_final_char),
        .i_cfg        (r_cfg),
        .o_reason     (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_final_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_final_char) begin
            r_accepted    <= (reason == havu_pkg::REASON_OK);
            r_fail_reason <= reason;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_fail_reason = r_fail_reason;

`ifndef ASSERT_OFF
    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accepted == (o_fail_reason == havu_pkg::REASON_OK)))
        else $error("accepted flag disagrees with fail reason");

    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fail_reason <= havu_pkg::REASON_FEW_DOTS))
        else $error("fail reason out of range");

    a_no_spurious_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(r_in_valid && r_final_char)) |=> !o_out_valid)
        else $error("verdict without a final item");

    a_final_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_final_char && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while final item is blocked");
`endif

endmodule
`default_nettype wire

@@ sim/hierarchical_address_validator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_address_validator_unit_tb
// Streams dotted addresses into the validator one character item at a time
// and keeps its own copy of the address checks. Each verdict is compared
// field by field with the oldest expected one. The limits are changed over
// APB between phases, including the extreme settings. Both handshakes idle
// and stall at random.
// ----------------------------------------------------------------------------
module hierarchical_address_validator_unit_tb;

    localparam int CycleLimit = 500000;
    localparam int ItemTarget = 1300;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_code   = 8'd0;
    logic        i_final_char  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic        o_accepted;
    logic [2:0]  o_fail_reason;

    hierarchical_address_validator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_final_char  (i_final_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accepted    (o_accepted),
        .o_fail_reason (o_fail_reason)
    );

    havu_pkg::t_cfg    limits = havu_pkg::CfgReset;
    havu_pkg::t_reason verdict_q[$];
    logic [7:0]  addr_text[$];
    int          err_count   = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          out_hold    = 0;
    bit          steady      = 1'b0;

    logic        in_call;
    logic [3:0]  call_len;
    logic [3:0]  call_digits;
    logic        call_nonalnum;
    logic        call_bad;
    logic        last_dot;
    logic        double_dot;
    logic        illegal_seen;
    logic [3:0]  dots_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("hierarchical_address_validator_unit_tb: errors");
        $finish;
    end

    function automatic int stall_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 11);
        return $urandom_range(19, 39);
    endfunction

    function automatic int ready_run();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 6);
        return $urandom_range(30, 100);
    endfunction

    function automatic int sender_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 30);
    endfunction

    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
            out_hold    <= 0;
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            out_hold    <= stall_cycles();
        end else begin
            i_out_ready <= 1'b1;
            out_hold    <= ready_run();
        end
    end

    always @(posedge i_clk) begin
        havu_pkg::t_reason want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected: accepted %0b fail_reason %0d",
                       o_accepted, o_fail_reason);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_accepted !== (want == havu_pkg::REASON_OK)) begin
                    $error("accepted: expected %0b, got %0b",
                           want == havu_pkg::REASON_OK, o_accepted);
                    err_count++;
                end
                if (o_fail_reason !== want) begin
                    $error("fail_reason: expected %0d, got %0d", want, o_fail_reason);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [3:0] bump(input logic [3:0] v);
        return (v == havu_pkg::CntMax) ? v : v + 4'd1;
    endfunction

    task automatic clear_address();
        in_call       = 1'b1;
        call_len      = 4'd0;
        call_digits   = 4'd0;
        call_nonalnum = 1'b0;
        call_bad      = 1'b0;
        last_dot      = 1'b0;
        double_dot    = 1'b0;
        illegal_seen  = 1'b0;
        dots_seen     = 4'd0;
    endtask

    task automatic advance_check(input logic [7:0] ch, input logic fin);
        logic              is_dig;
        logic              is_up;
        logic              is_low;
        havu_pkg::t_reason why;
        is_dig = (ch >= havu_pkg::ChZero) && (ch <= havu_pkg::ChNine);
        is_up  = (ch >= havu_pkg::ChUpA) && (ch <= havu_pkg::ChUpZ);
        is_low = (ch >= havu_pkg::ChLowA) && (ch <= havu_pkg::ChLowZ);
        if (ch == havu_pkg::ChDot) begin
            if (last_dot) double_dot = 1'b1;
            if (in_call) begin
                call_bad = call_nonalnum
                    || call_len < limits.call_min_length
                    || call_len > limits.call_max_length
                    || call_digits == 4'd0
                    || call_digits > limits.call_max_digits;
                in_call = 1'b0;
            end
            dots_seen = bump(dots_seen);
            last_dot  = 1'b1;
        end else begin
            if (in_call) begin
                if (!(is_dig || is_up || is_low)) call_nonalnum = 1'b1;
                if (is_dig) call_digits = bump(call_digits);
                call_len = bump(call_len);
            end
            last_dot = 1'b0;
        end
        if (!(is_dig || is_up || ch == havu_pkg::ChHash || ch == havu_pkg::ChDot)) begin
            illegal_seen = 1'b1;
        end
        if (fin) begin
            if (call_bad) why = havu_pkg::REASON_BAD_CALL;
            else if (double_dot) why = havu_pkg::REASON_DOUBLE_DOT;
            else if (illegal_seen) why = havu_pkg::REASON_ILLEGAL;
            else if (last_dot) why = havu_pkg::REASON_ENDS_DOT;
            else if (dots_seen < limits.min_dot_count) why = havu_pkg::REASON_FEW_DOTS;
            else why = havu_pkg::REASON_OK;
            verdict_q.push_back(why);
            clear_address();
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_code  <= ch;
        i_final_char <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        advance_check(ch, fin);
        items_sent++;
    endtask

    task automatic send_address();
        foreach (addr_text[i]) send_char(addr_text[i], i == addr_text.size() - 1);
    endtask

    task automatic send_text(input string s);
        addr_text.delete();
        for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
        send_address();
    endtask

    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input havu_pkg::t_reg_idx idx, input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            havu_pkg::REG_CALL_MIN_LENGTH: limits.call_min_length = val;
            havu_pkg::REG_CALL_MAX_LENGTH: limits.call_max_length = val;
            havu_pkg::REG_CALL_MAX_DIGITS: limits.call_max_digits = val;
            havu_pkg::REG_MIN_DOT_COUNT:   limits.min_dot_count   = val;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input havu_pkg::t_cfg c);
        write_limit(havu_pkg::REG_CALL_MIN_LENGTH, c.call_min_length);
        write_limit(havu_pkg::REG_CALL_MAX_LENGTH, c.call_max_length);
        write_limit(havu_pkg::REG_CALL_MAX_DIGITS, c.call_max_digits);
        write_limit(havu_pkg::REG_MIN_DOT_COUNT, c.min_dot_count);
    endtask

    function automatic havu_pkg::t_cfg random_limits();
        havu_pkg::t_cfg c;
        c.call_min_length = 4'($urandom_range(0, 5));
        c.call_max_length = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(2, 8));
        c.call_max_digits = 4'($urandom_range(0, 4));
        c.min_dot_count   = 4'($urandom_range(0, 4));
        return c;
    endfunction

    function automatic logic [7:0] legal_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return havu_pkg::ChUpA + 8'($urandom_range(0, 25));
        if (r < 85) return havu_pkg::ChZero + 8'($urandom_range(0, 9));
        return havu_pkg::ChHash;
    endfunction

    function automatic logic [7:0] call_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return havu_pkg::ChZero + 8'($urandom_range(0, 9));
        if (r < 33) return havu_pkg::ChLowA + 8'($urandom_range(0, 25));
        if (r < 35) return 8'($urandom_range(0, 255));
        return havu_pkg::ChUpA + 8'($urandom_range(0, 25));
    endfunction

    task automatic build_random_address();
        int kind;
        int n;
        int groups;
        int glen;
        addr_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                addr_text.push_back(($urandom_range(0, 3) == 0) ?
                                    havu_pkg::ChDot : 8'($urandom_range(0, 255)));
            end
        end else if (kind < 15) begin
            addr_text.push_back(legal_char());
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(2, 7);
            repeat (n) addr_text.push_back(call_char());
            groups = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            repeat (groups) begin
                addr_text.push_back(havu_pkg::ChDot);
                glen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
                repeat (glen) begin
                    addr_text.push_back(($urandom_range(0, 29) == 0) ?
                                        8'($urandom_range(0, 255)) : legal_char());
                end
            end
            if ($urandom_range(0, 19) == 0) addr_text.push_back(havu_pkg::ChDot);
            if (addr_text.size() == 0) addr_text.push_back(legal_char());
        end
    endtask

    task automatic run_batch(input int n_addr);
        repeat (n_addr) begin
            build_random_address();
            send_address();
        end
    endtask

    task automatic test_directed_verdicts();
        send_text("G1A.B.C");
        send_text("..");
        send_text("G1A..B");
        send_text("G1A.b.C");
        send_text("G1A.B.");
        send_text("#");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_saturation();
        apply_limits('{4'd0, 4'd15, 4'd15, 4'd15});
        addr_text.delete();
        repeat (17) addr_text.push_back(havu_pkg::ChZero + 8'($urandom_range(0, 9)));
        repeat (16) begin
            addr_text.push_back(havu_pkg::ChDot);
            addr_text.push_back(havu_pkg::ChUpA);
        end
        send_address();
        addr_text.delete();
        repeat (17) addr_text.push_back(havu_pkg::ChUpA + 8'($urandom_range(0, 25)));
        addr_text.push_back(havu_pkg::ChNine);
        repeat (14) begin
            addr_text.push_back(havu_pkg::ChDot);
            addr_text.push_back(havu_pkg::ChHash);
        end
        send_address();
        addr_text.delete();
        addr_text.push_back(havu_pkg::ChUpA);
        addr_text.push_back(havu_pkg::ChZero);
        repeat (16) addr_text.push_back(havu_pkg::ChDot);
        send_address();
        drain_verdicts();
    endtask

    task automatic test_limit_extremes();
        havu_pkg::t_cfg corners[6];
        corners[0] = '{4'd0, 4'd15, 4'd15, 4'd0};
        corners[1] = '{4'd15, 4'd15, 4'd1, 4'd15};
        corners[2] = '{4'd0, 4'd0, 4'd0, 4'd0};
        corners[3] = '{4'd15, 4'd0, 4'd15, 4'd1};
        corners[4] = '{4'd1, 4'd3, 4'd1, 4'd1};
        corners[5] = havu_pkg::CfgReset;
        foreach (corners[k]) begin
            apply_limits(corners[k]);
            run_batch(10);
            drain_verdicts();
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            run_batch(4);
            drain_verdicts();
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        phase = 0;
        while (items_sent < ItemTarget) begin
            apply_limits(random_limits());
            steady = (phase == 3);
            run_batch($urandom_range(10, 30));
            drain_verdicts();
            steady = 1'b0;
            phase++;
        end
    endtask

    initial begin
        clear_address();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_verdicts();
        test_saturation();
        test_limit_extremes();
        test_drain_pause();
        test_random_traffic();
        drain_verdicts();
        repeat (6) @(posedge i_clk);
        err_count += verdict_q.size();
        if (err_count == 0) begin
            $display("hierarchical_address_validator_unit_tb: clean");
        end else begin
            $display("hierarchical_address_validator_unit_tb: errors");
        end
        $finish;
    end

endmodule
